// File: rtl/core/sfr_pkg.sv
// shared types, codes and constants for the stream find-and-replace block
// no dependencies
package sfr_pkg;

  localparam int SFR_MAX_PATTERN = 16;
  localparam int SFR_MAX_REPL    = 16;
  localparam int SFR_LEN_W       = 5;
  localparam int SFR_REPL_IDX_W  = 4;
  localparam logic [7:0] SFR_NEWLINE = 8'd10;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_PAT_LO  = 3'd0,
    REG_PAT_HI  = 3'd1,
    REG_REPL_LO = 3'd2,
    REG_REPL_HI = 3'd3,
    REG_PAT_LEN = 3'd4,
    REG_REPL_LEN = 3'd5
  } sfr_reg_t;

  // request kinds on the input channel
  localparam logic REQ_TEXT = 1'b0;
  localparam logic REQ_EOL  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPL,
    ST_FLUSH
  } sfr_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic shift_emit;
    logic emit_repl;
    logic emit_nl;
    logic clear_count;
    logic last;
  } sfr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic prefix;
    logic full;
    logic cnt_zero;
    logic cnt_one;
    logic shift_prefix;
    logic rep_none;
    logic rep_last;
    logic out_free;
  } sfr_stat_t;

endpackage

// File: rtl/core/sfr_in_if.sv
// input channel: text byte or end-of-line request
// depends on nothing
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] in_byte;

  modport source (output valid, output req_type, output in_byte, input ready);
  modport sink (input valid, input req_type, input in_byte, output ready);
endinterface

// File: rtl/core/sfr_out_if.sv
// output channel: one emitted byte per word
// depends on nothing
interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: rtl/core/sfr_cfg_if.sv
// configuration write channel: register index and write data
// depends on nothing
interface sfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/sfr_dp.sv
// datapath: config registers, held-byte shift line, prefix compare, output register
// depends on sfr_pkg, sfr_out_if, sfr_cfg_if
module sfr_dp #(
  parameter int MAX_PATTERN = sfr_pkg::SFR_MAX_PATTERN
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        in_byte,
  input  sfr_pkg::sfr_cmd_t cmd,
  output sfr_pkg::sfr_stat_t stat,
  sfr_out_if.source         out_ch,
  sfr_cfg_if.sink           cfg
);

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);

  logic [63:0] pat_lo;
  logic [63:0] pat_hi;
  logic [63:0] repl_lo;
  logic [63:0] repl_hi;
  logic [CNT_W-1:0] pat_len;
  logic [sfr_pkg::SFR_LEN_W-1:0] repl_len;

  logic [7:0] held [MAX_PATTERN];
  logic [CNT_W-1:0] held_count;
  logic [sfr_pkg::SFR_REPL_IDX_W-1:0] rep_idx;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;

  logic [127:0] pat_vec;
  logic [127:0] repl_vec;
  logic [7:0]   repl_byte;
  logic         cfg_wr;
  logic         pat_wr;
  logic         emit;
  logic [sfr_pkg::SFR_LEN_W-1:0] cfg_len;

  assign pat_vec   = {pat_hi, pat_lo};
  assign repl_vec  = {repl_hi, repl_lo};
  assign repl_byte = repl_vec[{rep_idx, 3'b000} +: 8];
  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid;
  assign cfg_len   = cfg.data[sfr_pkg::SFR_LEN_W-1:0];
  assign pat_wr    = cfg_wr && (cfg.index == sfr_pkg::REG_PAT_LO ||
                                cfg.index == sfr_pkg::REG_PAT_HI ||
                                cfg.index == sfr_pkg::REG_PAT_LEN);
  assign emit      = cmd.shift_emit || cmd.emit_repl || cmd.emit_nl;

  // config registers, lengths clamped on write
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_lo   <= '0;
      pat_hi   <= '0;
      repl_lo  <= '0;
      repl_hi  <= '0;
      pat_len  <= CNT_W'(1);
      repl_len <= '0;
    end else if (cfg_wr) begin
      unique case (cfg.index)
        sfr_pkg::REG_PAT_LO:  pat_lo  <= cfg.data;
        sfr_pkg::REG_PAT_HI:  pat_hi  <= cfg.data;
        sfr_pkg::REG_REPL_LO: repl_lo <= cfg.data;
        sfr_pkg::REG_REPL_HI: repl_hi <= cfg.data;
        sfr_pkg::REG_PAT_LEN: begin
          if (cfg_len == '0) begin
            pat_len <= CNT_W'(1);
          end else if (cfg_len > sfr_pkg::SFR_LEN_W'(MAX_PATTERN)) begin
            pat_len <= CNT_W'(MAX_PATTERN);
          end else begin
            pat_len <= CNT_W'(cfg_len);
          end
        end
        sfr_pkg::REG_REPL_LEN: begin
          if (cfg_len > sfr_pkg::SFR_LEN_W'(sfr_pkg::SFR_MAX_REPL)) begin
            repl_len <= sfr_pkg::SFR_LEN_W'(sfr_pkg::SFR_MAX_REPL);
          end else begin
            repl_len <= cfg_len;
          end
        end
        default: ;
      endcase
    end
  end

  // held bytes: append at the fill point, shift out from the front
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (cmd.load && CNT_W'(i) == held_count) begin
        held[i] <= in_byte;
      end else if (cmd.shift_emit && i < MAX_PATTERN - 1) begin
        held[i] <= held[(i < MAX_PATTERN - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (pat_wr || cmd.clear_count) begin
      held_count <= '0;
    end else if (cmd.load) begin
      held_count <= held_count + CNT_W'(1);
    end else if (cmd.shift_emit) begin
      held_count <= held_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_idx <= '0;
    end else if (cmd.load) begin
      rep_idx <= '0;
    end else if (cmd.emit_repl) begin
      rep_idx <= rep_idx + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_last <= cmd.last;
      priority if (cmd.shift_emit) begin
        out_byte <= held[0];
      end else if (cmd.emit_repl) begin
        out_byte <= repl_byte;
      end else begin
        out_byte <= sfr_pkg::SFR_NEWLINE;
      end
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.out_byte    = out_byte;
  assign out_ch.last_of_run = out_last;

  // prefix checks on the held bytes and on the held bytes after one shift
  always_comb begin
    stat.prefix       = 1'b1;
    stat.shift_prefix = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (CNT_W'(i) < held_count && held[i] != pat_vec[i*8 +: 8]) begin
        stat.prefix = 1'b0;
      end
    end
    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
      if (CNT_W'(i + 1) < held_count && held[(i < MAX_PATTERN - 1) ? i + 1 : i] !=
          pat_vec[i*8 +: 8]) begin
        stat.shift_prefix = 1'b0;
      end
    end
    stat.full     = held_count >= pat_len;
    stat.cnt_zero = held_count == '0;
    stat.cnt_one  = held_count == CNT_W'(1);
    stat.rep_none = repl_len == '0;
    stat.rep_last = {1'b0, rep_idx} == repl_len - 1'b1;
    stat.out_free = !out_valid || out_ch.ready;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(MAX_PATTERN))
    else $error("held count beyond buffer depth");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || out_ch.ready))
    else $error("emit into an occupied output register");

  a_load_room: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> held_count < pat_len)
    else $error("append with a full match still held");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("emitted word not presented");
`endif

endmodule

// File: rtl/core/sfr_ctrl.sv
// controller state machine: sequences scan, replacement and flush steps
// depends on sfr_pkg
module sfr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               req_type,
  output logic               in_ready,
  input  sfr_pkg::sfr_stat_t stat,
  output sfr_pkg::sfr_cmd_t  cmd
);

  sfr_pkg::sfr_state_t state;
  sfr_pkg::sfr_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      sfr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (req_type == sfr_pkg::REQ_EOL) begin
            state_next = sfr_pkg::ST_FLUSH;
          end else begin
            cmd.load   = 1'b1;
            state_next = sfr_pkg::ST_SCAN;
          end
        end
      end
      sfr_pkg::ST_SCAN: begin
        if (stat.prefix) begin
          if (!stat.full) begin
            state_next = sfr_pkg::ST_IDLE;
          end else if (stat.rep_none) begin
            cmd.clear_count = 1'b1;
            state_next      = sfr_pkg::ST_IDLE;
          end else begin
            state_next = sfr_pkg::ST_REPL;
          end
        end else if (stat.out_free) begin
          // oldest byte leaves; done if what stays is a partial match
          cmd.shift_emit = 1'b1;
          cmd.last       = stat.cnt_one || stat.shift_prefix;
          if (cmd.last) begin
            state_next = sfr_pkg::ST_IDLE;
          end
        end
      end
      sfr_pkg::ST_REPL: begin
        if (stat.out_free) begin
          cmd.emit_repl = 1'b1;
          cmd.last      = stat.rep_last;
          if (stat.rep_last) begin
            cmd.clear_count = 1'b1;
            state_next      = sfr_pkg::ST_IDLE;
          end
        end
      end
      sfr_pkg::ST_FLUSH: begin
        if (stat.out_free) begin
          if (stat.cnt_zero) begin
            cmd.emit_nl = 1'b1;
            cmd.last    = 1'b1;
            state_next  = sfr_pkg::ST_IDLE;
          end else begin
            cmd.shift_emit = 1'b1;
          end
        end
      end
      default: state_next = sfr_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: rtl/core/stream_find_replace.sv
// top level of the stream find-and-replace block
// depends on sfr_pkg, sfr_in_if, sfr_out_if, sfr_cfg_if, sfr_ctrl, sfr_dp
//
// streaming find-and-replace over text words: every leftmost non-overlapping
// occurrence of the pattern (1 to MAX_PATTERN bytes) in a line is replaced by
// the replacement (0 to 16 bytes, zero deletes). bytes that may still start a
// match are held back; when they stop matching the oldest is sent and the rest
// rechecked. an end-of-line word flushes the held bytes and then a newline (10).
// last_of_run marks the final output word caused by one input word; an input
// that only grows a partial match, or a match deleted by an empty replacement,
// gives no output. when the held bytes stop matching, each recheck shares the
// cycle of its send. a new word is taken only once the previous one has been
// fully worked off, set by the single controller sequencing one output word
// per cycle into the output register while the sink keeps up, which lets the
// last word wait for the sink while the next input is taken.
// configuration writes are always ready and must only be issued while idle;
// pattern or pattern length writes drop any held bytes.
module stream_find_replace #(
  parameter int MAX_PATTERN = sfr_pkg::SFR_MAX_PATTERN
) (
  input logic        clk,
  input logic        rst,
  sfr_in_if.sink     in_ch,
  sfr_out_if.source  out_ch,
  sfr_cfg_if.sink    cfg
);

  // command and status between controller and datapath
  sfr_pkg::sfr_cmd_t  cmd;
  sfr_pkg::sfr_stat_t stat;

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .req_type (in_ch.req_type),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfr_dp #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_byte (in_ch.in_byte),
    .cmd     (cmd),
    .stat    (stat),
    .out_ch  (out_ch),
    .cfg     (cfg)
  );

endmodule

// File: sim/stream_find_replace_tb.sv
// self-checking testbench for stream_find_replace: directed lines, then random text per setting
// depends on sfr_pkg, sfr_in_if, sfr_out_if, sfr_cfg_if and the stream_find_replace rtl
module stream_find_replace_tb;

  // indexes past the register map, writes there must change nothing
  localparam logic [2:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_B = 8'h62;

  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 38;
  localparam int SETTLE_TICKS = 20;

  // which bytes the random text is drawn from
  typedef enum int {
    TWO_LETTERS,
    ANY_BYTE,
    PATTERN_BYTES
  } text_mix_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } text_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } emit_word_t;

  logic clk;
  logic rst;

  sfr_in_if  text_ch ();
  sfr_out_if emit_ch ();
  sfr_cfg_if cfg_ch ();

  stream_find_replace i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (text_ch),
    .out_ch (emit_ch),
    .cfg    (cfg_ch)
  );

  // words waiting for the driver, and output words the block still owes us
  text_word_t word_q[$];
  emit_word_t owed_q[$];

  int unsigned words_queued;
  int unsigned words_taken;
  int unsigned words_emitted;
  int unsigned mismatches;
  int unsigned matches_seen;
  int unsigned rescans_seen;
  int unsigned flushes_seen;
  int unsigned settings_used;

  // when set, neither side ever idles
  bit steady;

  // mirror of the block's registers and hold buffer
  logic [63:0] pat_lo, pat_hi, rep_lo, rep_hi;
  logic [4:0]  pat_len_reg, rep_len_reg;
  logic [7:0]  held [sfr_pkg::SFR_MAX_PATTERN];
  int          held_n;

  // what the text generator believes the pattern is
  logic [63:0] gen_pat_lo, gen_pat_hi;
  int          gen_plen;

  // byte i of a pair of 64-bit byte registers, byte 0 lowest
  function automatic logic [7:0] byte_at(logic [63:0] lo, logic [63:0] hi, int i);
    logic [63:0] w;
    w = ((i & 15) < 8) ? lo : hi;
    return w[(i & 7) * 8 +: 8];
  endfunction

  // zero means one, anything past the buffer saturates
  function automatic int live_pat_len(logic [4:0] v);
    if (v == 0) return 1;
    if (v > sfr_pkg::SFR_MAX_PATTERN) return sfr_pkg::SFR_MAX_PATTERN;
    return int'(v);
  endfunction

  function automatic int live_rep_len(logic [4:0] v);
    return (v > sfr_pkg::SFR_MAX_REPL) ? sfr_pkg::SFR_MAX_REPL : int'(v);
  endfunction

  function automatic bit held_is_pattern_start();
    for (int i = 0; i < held_n; i++)
      if (held[i] !== byte_at(pat_lo, pat_hi, i)) return 1'b0;
    return 1'b1;
  endfunction

  // register write as the block sees it; pattern changes drop the held bytes
  function automatic void apply_reg(logic [2:0] idx, logic [63:0] d);
    case (idx)
      sfr_pkg::REG_PAT_LO: begin
        pat_lo = d;
        held_n = 0;
      end
      sfr_pkg::REG_PAT_HI: begin
        pat_hi = d;
        held_n = 0;
      end
      sfr_pkg::REG_REPL_LO: rep_lo = d;
      sfr_pkg::REG_REPL_HI: rep_hi = d;
      sfr_pkg::REG_PAT_LEN: begin
        pat_len_reg = d[4:0];
        held_n = 0;
      end
      sfr_pkg::REG_REPL_LEN: rep_len_reg = d[4:0];
      default: ;
    endcase
  endfunction

  // work out the output words one accepted input word causes
  function automatic void predict_replace(text_word_t w);
    emit_word_t run[$];
    int         plen;
    plen = live_pat_len(pat_len_reg);
    if (w.kind == sfr_pkg::REQ_EOL) begin
      // flush held bytes as they are, then the newline
      if (held_n > 0) flushes_seen++;
      for (int i = 0; i < held_n; i++) run.push_back('{held[i], 1'b0});
      held_n = 0;
      run.push_back('{sfr_pkg::SFR_NEWLINE, 1'b0});
    end else begin
      held[held_n] = w.data;
      held_n++;
      while (held_n > 0) begin
        if (held_is_pattern_start()) begin
          if (held_n >= plen) begin
            // full match, inserted text is never rescanned
            matches_seen++;
            for (int i = 0; i < live_rep_len(rep_len_reg); i++)
              run.push_back('{byte_at(rep_lo, rep_hi, i), 1'b0});
            held_n = 0;
          end
          break;
        end
        // oldest byte cannot start a match: send it, recheck the rest
        rescans_seen++;
        run.push_back('{held[0], 1'b0});
        for (int i = 0; i + 1 < held_n; i++) held[i] = held[i + 1];
        held_n--;
      end
    end
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) owed_q.push_back(run[i]);
  endfunction

  task automatic flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver: hands queued words to the block, idling at random unless steady
  always @(posedge clk) begin
    text_word_t w;
    if (rst) begin
      text_ch.valid <= 1'b0;
    end else if (!text_ch.valid || text_ch.ready) begin
      if (word_q.size() > 0 && (steady || $urandom_range(99) >= 37)) begin
        w = word_q.pop_front();
        text_ch.valid    <= 1'b1;
        text_ch.req_type <= w.kind;
        text_ch.in_byte  <= w.data;
      end else begin
        text_ch.valid <= 1'b0;
      end
    end
  end

  // output side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      emit_ch.ready <= 1'b0;
    end else begin
      emit_ch.ready <= steady || ($urandom_range(99) >= 37);
    end
  end

  // monitor: config writes, accepted input words and output words are all
  // handled in this one process so their order at an edge is fixed
  always @(posedge clk) begin
    emit_word_t want;
    if (rst) begin
      pat_lo      = '0;
      pat_hi      = '0;
      rep_lo      = '0;
      rep_hi      = '0;
      pat_len_reg = 5'd1;
      rep_len_reg = '0;
      held_n      = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) apply_reg(cfg_ch.index, cfg_ch.data);
      if (text_ch.valid && text_ch.ready) begin
        words_taken++;
        predict_replace('{text_ch.req_type, text_ch.in_byte});
      end
      if (emit_ch.valid && emit_ch.ready) begin
        words_emitted++;
        if (owed_q.size() == 0) begin
          flag_mismatch($sformatf("word %02h with nothing owed", emit_ch.out_byte));
        end else begin
          want = owed_q.pop_front();
          if (emit_ch.out_byte !== want.data)
            flag_mismatch($sformatf("out_byte %02h, wanted %02h",
                                    emit_ch.out_byte, want.data));
          if (emit_ch.last_of_run !== want.last)
            flag_mismatch($sformatf("last_of_run %b, wanted %b on byte %02h",
                                    emit_ch.last_of_run, want.last, want.data));
        end
      end
    end
  end

  function automatic void queue_word(logic kind, logic [7:0] b);
    word_q.push_back('{kind, b});
    words_queued++;
  endfunction

  // called at a rising edge; leaves valid high so back-to-back writes never toggle it
  task automatic write_reg(logic [2:0] idx, logic [63:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // every word taken, every owed word seen, then a settling wait so that a
  // held byte that gives no output can finish inside the block
  task automatic wait_idle();
    while (words_taken != words_queued || owed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic load_setting(logic [127:0] pat, logic [127:0] rep,
                              logic [4:0] plen, logic [4:0] rlen);
    logic [63:0] noise_p, noise_r;
    noise_p = {$urandom, $urandom};
    noise_r = {$urandom, $urandom};
    write_reg(sfr_pkg::REG_PAT_LO, pat[63:0]);
    write_reg(sfr_pkg::REG_PAT_HI, pat[127:64]);
    write_reg(sfr_pkg::REG_REPL_LO, rep[63:0]);
    write_reg(sfr_pkg::REG_REPL_HI, rep[127:64]);
    write_reg(sfr_pkg::REG_PAT_LEN, {noise_p[63:5], plen});
    write_reg(sfr_pkg::REG_REPL_LEN, {noise_r[63:5], rlen});
    cfg_ch.valid <= 1'b0;
    gen_pat_lo = pat[63:0];
    gen_pat_hi = pat[127:64];
    gen_plen   = live_pat_len(plen);
    settings_used++;
  endtask

  function automatic logic [7:0] pick_byte(text_mix_t mix);
    case (mix)
      TWO_LETTERS: return 8'($urandom_range(CH_B, CH_A));
      ANY_BYTE:    return 8'($urandom_range(255));
      default:     return byte_at(gen_pat_lo, gen_pat_hi, $urandom_range(gen_plen - 1));
    endcase
  endfunction

  // one line of text: mostly whole matches and broken prefixes, some noise
  function automatic void queue_line(text_mix_t mix, bit with_eol);
    int toks, k, p;
    toks = $urandom_range(10);
    for (int t = 0; t < toks; t++) begin
      k = $urandom_range(99);
      if (k < 35) begin
        for (int i = 0; i < gen_plen; i++)
          queue_word(sfr_pkg::REQ_TEXT, byte_at(gen_pat_lo, gen_pat_hi, i));
      end else if (k < 60 && gen_plen > 1) begin
        p = $urandom_range(gen_plen - 1, 1);
        for (int i = 0; i < p; i++)
          queue_word(sfr_pkg::REQ_TEXT, byte_at(gen_pat_lo, gen_pat_hi, i));
        queue_word(sfr_pkg::REQ_TEXT, pick_byte(mix));
      end else if (k < 85) begin
        queue_word(sfr_pkg::REQ_TEXT, pick_byte(mix));
      end else begin
        queue_word(sfr_pkg::REQ_TEXT, 8'($urandom_range(255)));
      end
    end
    if (with_eol) queue_word(sfr_pkg::REQ_EOL, 8'($urandom_range(255)));
  endfunction

  // stimulus
  initial begin
    int          start, e, guard;
    bit          paused;
    text_mix_t   mix;
    logic [127:0] pat, rep;
    logic [4:0]  plen, rlen;
    logic [7:0]  c;

    rst              = 1'b1;
    steady           = 1'b0;
    text_ch.valid    = 1'b0;
    text_ch.req_type = sfr_pkg::REQ_TEXT;
    text_ch.in_byte  = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    emit_ch.ready    = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset setting: one-byte pattern of zero, empty replacement deletes it
    queue_word(sfr_pkg::REQ_TEXT, 8'h00);
    queue_word(sfr_pkg::REQ_TEXT, 8'hff);
    queue_word(sfr_pkg::REQ_TEXT, 8'h00);
    queue_word(sfr_pkg::REQ_EOL, 8'h00);
    queue_word(sfr_pkg::REQ_EOL, 8'hff);
    wait_idle();

    // "aab": a third 'a' forces a rescan, then a full 16-byte replacement
    // from a saturated replacement length; two 'a' stay held
    pat = {$urandom, $urandom, $urandom, $urandom};
    pat[23:0] = {CH_B, CH_A, CH_A};
    load_setting(pat, {$urandom, $urandom, $urandom, $urandom}, 5'd3, 5'd31);
    queue_word(sfr_pkg::REQ_TEXT, CH_A);
    queue_word(sfr_pkg::REQ_TEXT, CH_A);
    queue_word(sfr_pkg::REQ_TEXT, CH_A);
    queue_word(sfr_pkg::REQ_TEXT, CH_B);
    queue_word(sfr_pkg::REQ_TEXT, CH_A);
    queue_word(sfr_pkg::REQ_TEXT, CH_A);
    wait_idle();

    // new replacement while bytes are held: they must survive
    write_reg(sfr_pkg::REG_REPL_LEN, 64'd2);
    write_reg(sfr_pkg::REG_REPL_LO, {$urandom, $urandom});
    cfg_ch.valid <= 1'b0;
    queue_word(sfr_pkg::REQ_TEXT, CH_B);
    queue_word(sfr_pkg::REQ_TEXT, CH_A);
    queue_word(sfr_pkg::REQ_EOL, 8'h00);
    wait_idle();

    // hold two bytes again, then change the pattern under them
    queue_word(sfr_pkg::REQ_TEXT, CH_A);
    queue_word(sfr_pkg::REQ_TEXT, CH_A);
    wait_idle();

    // zero pattern length acts as one; unmapped indexes are ignored
    write_reg(sfr_pkg::REG_PAT_LO, {$urandom, 24'($urandom), 8'hff});
    write_reg(sfr_pkg::REG_PAT_LEN, {$urandom, 27'($urandom), 5'd0});
    write_reg(sfr_pkg::REG_REPL_LEN, 64'd1);
    write_reg(REG_UNMAPPED_LO, {$urandom, $urandom});
    write_reg(REG_UNMAPPED_HI, {$urandom, $urandom});
    cfg_ch.valid <= 1'b0;
    settings_used++;
    queue_word(sfr_pkg::REQ_EOL, 8'h00);
    queue_word(sfr_pkg::REQ_TEXT, 8'hff);
    queue_word(sfr_pkg::REQ_TEXT, 8'h7f);
    queue_word(sfr_pkg::REQ_EOL, 8'h00);
    wait_idle();

    // random settings, each with a burst of text
    for (int ph = 0; ph < PHASES; ph++) begin
      mix = text_mix_t'(ph % 3);
      case (ph)
        0:       plen = 5'd16;
        1:       plen = 5'($urandom_range(31, 17));
        2:       plen = 5'd0;
        default: plen = 5'($urandom_range(16, 1));
      endcase
      case (ph % 4)
        0:       rlen = 5'd16;
        1:       rlen = 5'd0;
        2:       rlen = 5'($urandom_range(31, 17));
        default: rlen = 5'($urandom_range(15, 1));
      endcase
      e = live_pat_len(plen);
      case (mix)
        TWO_LETTERS: begin
          pat = {$urandom, $urandom, $urandom, $urandom};
          for (int i = 0; i < sfr_pkg::SFR_MAX_PATTERN; i++)
            pat[i * 8 +: 8] = 8'($urandom_range(CH_B, CH_A));
        end
        ANY_BYTE: pat = {$urandom, $urandom, $urandom, $urandom};
        default: begin
          // one repeated byte: heavy self-overlap, sometimes broken at the end
          c = 8'($urandom_range(255));
          pat = {16{c}};
          if ($urandom_range(1)) pat[(e - 1) * 8 +: 8] = 8'($urandom_range(255));
        end
      endcase
      rep = {$urandom, $urandom, $urandom, $urandom};
      load_setting(pat, rep, plen, rlen);

      steady = (ph == 5);
      start  = words_queued;
      paused = 1'b0;
      while (words_queued - start < PHASE_WORDS) begin
        // the last lines may stop short of a line end, leaving bytes held
        queue_line(mix, (words_queued - start < PHASE_WORDS - 8) || $urandom_range(1));
        if (ph == 3 && !paused && words_queued - start >= PHASE_WORDS / 2) begin
          // sender holds off until the block has caught up completely
          wait_idle();
          paused = 1'b1;
        end
      end
      wait_idle();
      steady = 1'b0;
    end

    // drain, bounded, then a short tail for stray output
    for (guard = 0; guard < 200000 && (words_taken != words_queued || owed_q.size() != 0);
         guard++)
      @(posedge clk);
    repeat (30) @(posedge clk);
    if (owed_q.size() != 0)
      flag_mismatch($sformatf("%0d owed words never came out", owed_q.size()));

    $display("covered %0d words in, %0d out, over %0d settings", words_taken, words_emitted,
             settings_used);
    $display("saw %0d matches, %0d rescans, %0d line flushes of held bytes", matches_seen,
             rescans_seen, flushes_seen);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
